/* hw/rtl/nearest_vertex_search_defines.svh */
// Assertion macros for the nearest vertex search block.
// Included by files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef NEAREST_VERTEX_SEARCH_DEFINES_SVH
`define NEAREST_VERTEX_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset
`define NVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included
`define NVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NVS_ASSERT(lbl, prop, msg)
`define NVS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/nvs_pkg.sv */
// Shared types and constants of the nearest vertex search block.
// No dependencies; imported by the top level.
`default_nettype none

package nvs_pkg;

  // Default configuration
  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 20;

  // Fixed field widths
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned SQ_OUT_W   = 44;
  localparam int unsigned DIST_OUT_W = 22;
  localparam int unsigned STATUS_W   = 2;

  // Query filter that matches every vertex type
  localparam logic [KIND_W-1:0] KIND_ANY = 3'd7;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* hw/rtl/nvs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module nvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/nvs_sqrt.sv */
// Iterative floor square root, one result bit per cycle (digit-by-digit restoring form).
// No dependencies; instanced by the nearest vertex search top level.
`default_nettype none

module nvs_sqrt #(
  parameter int unsigned IN_W = 44
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [IN_W-1:0]     radicand_i,
  output logic                     done_o,
  output logic      [IN_W/2-1:0]   root_o
);

  localparam int unsigned RW    = IN_W / 2;
  localparam int unsigned CNT_W = $clog2(RW);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } sq_state_e;

  sq_state_e        state_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IN_W-1:0]  rad_q;
  logic [RW+1:0]    rem_q;
  logic [RW-1:0]    root_q;

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;

  // One step: bring down two radicand bits and try the next root bit
  assign rem_sh = {rem_q[RW-1:0], rad_q[IN_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign take   = rem_sh >= trial;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            cnt_q   <= CNT_W'(RW - 1);
            state_q <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= SQ_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (state_q == SQ_IDLE && start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == SQ_RUN) begin
      rad_q  <= rad_q << 2;
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* hw/rtl/nearest_vertex_search.sv */
// Nearest vertex search: vertex table in RAM, one shared squaring multiplier, iterative sqrt.
// Depends on nvs_pkg, nvs_ram, nvs_sqrt and nearest_vertex_search_defines.svh.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low. req_type_i
//   selects append (store point and kind at the next index) or query (nearest stored
//   vertex to the point, kind 7 matching every type). Each transaction gives exactly
//   one result, shown on the result ports for a single cycle with done_o high; the
//   receiver cannot stall it and must take it in that cycle.
//   Append: done_o rises the cycle after the transaction; busy drops the cycle after that.
//   Query: FETCH reads the first vertex; for each vertex that matches the filter, the scan
//   squares dx (MULX) and dy (MULY), both through the one multiplier, then adds and
//   compares (ACC); a skipped vertex leaves after MULX. The square root then gives one
//   root bit per cycle, MAG_W + 1 bits (22 at default width); a query that finds
//   nothing skips the root.
//   The next transaction is taken the cycle after done_o.
//   Reset empties the table (count to zero) at once; no clearing pass is needed.
`default_nettype none
`include "nearest_vertex_search_defines.svh"

module nearest_vertex_search import nvs_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         req_type_i,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic        [KIND_W-1:0]     vertex_kind_i,
  output logic                              done_o,
  output logic             [STATUS_W-1:0]   status_o,
  output logic             [INDEX_W-1:0]    vertex_index_o,
  output logic             [SQ_OUT_W-1:0]   squared_distance_o,
  output logic             [DIST_OUT_W-1:0] distance_o
);

  localparam int unsigned ADDR_W     = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W      = $clog2(MAX_VERTICES + 1);
  localparam int unsigned MAG_W      = COORD_BITS + 1;
  localparam int unsigned PROD_W     = 2 * MAG_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned SQRT_IN_W  = PROD_W + 2;
  localparam int unsigned ROOT_W     = SQRT_IN_W / 2;
  localparam int unsigned RAM_W      = 2 * COORD_BITS + KIND_W;
  localparam int unsigned CHK_W      = 2 * DIST_OUT_W + 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_MULX  = 7'b0000100,
    S_MULY  = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // Control registers
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              found_q, found_d;

  // Working registers
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [KIND_W-1:0]     kind_q;
  logic [ADDR_W-1:0]     last_q;
  logic [MAG_W-1:0]      dy_q;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W-1:0]     acc_q;
  logic [SUM_W-1:0]      best_q, best_d;
  logic [ADDR_W-1:0]     best_idx_q, best_idx_d;

  // Result registers
  status_e               status_q;
  logic [INDEX_W-1:0]    index_q;
  logic [SQ_OUT_W-1:0]   sq_q;
  logic [DIST_OUT_W-1:0] dist_q;

  // Result load from the sequencer
  logic                  res_load;
  status_e               res_status;
  logic [INDEX_W-1:0]    res_index;
  logic [SQ_OUT_W-1:0]   res_sq;
  logic [DIST_OUT_W-1:0] res_dist;

  logic                  accept;
  logic                  finish;
  logic                  wr_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [RAM_W-1:0]      rd_data;
  logic [COORD_BITS-1:0] rd_x, rd_y;
  logic [KIND_W-1:0]     rd_kind;
  logic                  match;
  logic [MAG_W-1:0]      dx, dy, dx_mag, dy_mag, mul_a;
  logic [PROD_W-1:0]     prod_d;
  logic [SUM_W-1:0]      sum;
  logic                  better;
  logic                  sqrt_start;
  logic [SQRT_IN_W-1:0]  sqrt_rad;
  logic                  sqrt_done;
  logic [ROOT_W-1:0]     sqrt_root;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign done_o = (state_q == S_DONE);

  // Vertex table: x, y and type packed in one word
  nvs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({point_x_i, point_y_i, vertex_kind_i}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Next vertex is addressed while the current one is in work
  assign rd_addr = (state_q == S_FETCH) ? '0 : idx_q + 1'b1;

  assign rd_x    = rd_data[RAM_W-1 -: COORD_BITS];
  assign rd_y    = rd_data[KIND_W +: COORD_BITS];
  assign rd_kind = rd_data[KIND_W-1:0];
  assign match   = (kind_q == KIND_ANY) || (rd_kind == kind_q);

  // Coordinate differences, sign extended by one bit, and their magnitudes
  assign dx     = {px_q[COORD_BITS-1], px_q} - {rd_x[COORD_BITS-1], rd_x};
  assign dy     = {py_q[COORD_BITS-1], py_q} - {rd_y[COORD_BITS-1], rd_y};
  assign dx_mag = dx[MAG_W-1] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[MAG_W-1] ? (~dy + 1'b1) : dy;

  // Shared squaring multiplier, output registered
  assign mul_a  = (state_q == S_MULX) ? dx_mag : dy_q;
  assign prod_d = mul_a * mul_a;

  // Distance accumulate and compare against the best so far
  assign sum    = SUM_W'(acc_q) + SUM_W'(prod_q);
  assign better = !found_q || (sum < best_q);

  nvs_sqrt #(
    .IN_W (SQRT_IN_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    found_d    = found_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    wr_en      = 1'b0;
    finish     = 1'b0;
    sqrt_start = 1'b0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_index  = '0;
    res_sq     = '0;
    res_dist   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_APPEND) begin
            res_load = 1'b1;
            state_d  = S_DONE;
            if (count_q == CNT_W'(MAX_VERTICES)) begin
              res_status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              res_index = INDEX_W'(count_q);
              count_d   = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            res_load   = 1'b1;
            res_status = ST_NONE;
            state_d    = S_DONE;
          end else begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: state_d = S_MULX;
      S_MULX: begin
        if (match) begin
          state_d = S_MULY;
        end else begin
          // skipped vertex moves on to the next index without squaring
          finish = (idx_q == last_q);
          idx_d  = idx_q + 1'b1;
        end
      end
      S_MULY: state_d = S_ACC;
      S_ACC: begin
        if (better) begin
          found_d    = 1'b1;
          best_d     = sum;
          best_idx_d = idx_q;
        end
        finish  = (idx_q == last_q);
        idx_d   = idx_q + 1'b1;
        state_d = S_MULX;
      end
      S_SQRT: begin
        if (sqrt_done) begin
          res_load  = 1'b1;
          res_index = INDEX_W'(best_idx_q);
          res_sq    = SQ_OUT_W'(best_q);
          res_dist  = DIST_OUT_W'(sqrt_root);
          state_d   = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    // End of scan: root of the winner, or no match
    if (finish) begin
      if (found_d) begin
        sqrt_start = 1'b1;
        state_d    = S_SQRT;
      end else begin
        res_load   = 1'b1;
        res_status = ST_NONE;
        state_d    = S_DONE;
      end
    end
  end

  assign sqrt_rad = SQRT_IN_W'(best_d);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      kind_q <= vertex_kind_i;
      last_q <= ADDR_W'(count_q - 1'b1);
    end
    if (state_q == S_MULX) begin
      dy_q <= dy_mag;
    end
    if (state_q == S_MULY) begin
      acc_q <= prod_q;
    end
    prod_q     <= prod_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    if (res_load) begin
      status_q <= res_status;
      index_q  <= res_index;
      sq_q     <= res_sq;
      dist_q   <= res_dist;
    end
  end

  assign status_o           = status_q;
  assign vertex_index_o     = index_q;
  assign squared_distance_o = sq_q;
  assign distance_o         = dist_q;

  // Assertions
  `NVS_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CNT_W'(MAX_VERTICES)), "vertex count past table size")
  `NVS_ASSERT(a_accept_busy, accept |=> busy, "transaction taken but block not busy")
  `NVS_ASSERT(a_sqrt_owner, sqrt_done |-> (state_q == S_SQRT), "root done outside root phase")
  `NVS_ASSERT(a_none_zero, (done_o && status_o == ST_NONE) |-> (vertex_index_o == '0 && squared_distance_o == '0 && distance_o == '0), "no-match result not zero")
  `NVS_ASSERT(a_root_floor, (done_o && status_o == ST_OK) |-> ((CHK_W'(distance_o) * CHK_W'(distance_o) <= CHK_W'(squared_distance_o)) && ((CHK_W'(distance_o) + 1'b1) * (CHK_W'(distance_o) + 1'b1) > CHK_W'(squared_distance_o))), "distance is not floor root")

endmodule

`default_nettype wire
